[rtl/core/rafk_pkg.sv]
// ----------------------------------------------------------------------------
// rafk_pkg
// Shared widths, angle constants, register indexes, the arctangent table and
// small helpers of the arm forward kinematics unit.
// ----------------------------------------------------------------------------
package rafk_pkg;

    localparam int STEP_W  = 32;   // motor step count
    localparam int F_W     = 21;   // packed register field
    localparam int CFG_W   = 63;   // widest configuration register
    localparam int ANG_W   = 32;   // angle, 2^-22 degree
    localparam int CS_W    = 32;   // CORDIC x/y, 2^-30
    localparam int POS_W   = 24;   // output coordinate
    localparam int LANES   = 5;    // sine/cosine evaluations per pose
    localparam int PROD_W  = STEP_W + F_W + 1;

    localparam int CORDIC_ITERATIONS_DEF = 24;

    // 360 degrees is 45 * 2^25 in angle units; steps*dps*4 >> 25 = prod >> 23
    localparam int QUO_LSB        = 23;
    localparam int MOD45_SIGN_ADJ = 7;     // -2^31 mod 45
    localparam int RECIP_45       = 23302; // ceil(2^20 / 45)
    localparam int RECIP_SHIFT    = 20;

    localparam logic signed [ANG_W-1:0] DEG_90  = 32'sd377487360;
    localparam logic signed [ANG_W-1:0] DEG_180 = 32'sd754974720;
    localparam logic signed [ANG_W-1:0] DEG_360 = 32'sd1509949440;
    localparam logic signed [CS_W-1:0]  CORDIC_X0 = 32'sd652032874;
    localparam logic signed [63:0]      HALF_Q30 = 64'sd536870912;
    localparam logic signed [31:0]      OUT_MAX = 32'sd8388607;
    localparam logic signed [31:0]      OUT_MIN = -32'sd8388608;

    // CORDIC lane assignment
    localparam int LANE_BASE  = 0;   // a1
    localparam int LANE_SHLD  = 1;   // a2
    localparam int LANE_ELBOW = 2;   // a2+a3
    localparam int LANE_PITCH = 3;   // a2+a3+a4
    localparam int LANE_WRIST = 4;   // a5

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_PIVOT    = 3'd1,
        REG_SHOULDER = 3'd2,
        REG_WRIST    = 3'd3,
        REG_UPPER    = 3'd4,
        REG_LOWER    = 3'd5,
        REG_DPS123   = 3'd6,
        REG_DPS45    = 3'd7
    } cfg_index_t;

    localparam logic [1:0] MODE_FIVE    = 2'd0;
    localparam logic [1:0] MODE_DERIVED = 2'd1;

    typedef struct packed {
        logic             valid;
        logic [LANES-1:0] neg;
    } cordic_ctl_t;

    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] k);
        logic signed [ANG_W-1:0] r;
        case (k)
            5'd0:  r = 32'sd188743680;
            5'd1:  r = 32'sd111421900;
            5'd2:  r = 32'sd58872272;
            5'd3:  r = 32'sd29884485;
            5'd4:  r = 32'sd15000234;
            5'd5:  r = 32'sd7507429;
            5'd6:  r = 32'sd3754631;
            5'd7:  r = 32'sd1877430;
            5'd8:  r = 32'sd938729;
            5'd9:  r = 32'sd469366;
            5'd10: r = 32'sd234683;
            5'd11: r = 32'sd117342;
            5'd12: r = 32'sd58671;
            5'd13: r = 32'sd29335;
            5'd14: r = 32'sd14668;
            5'd15: r = 32'sd7334;
            5'd16: r = 32'sd3667;
            5'd17: r = 32'sd1833;
            5'd18: r = 32'sd917;
            5'd19: r = 32'sd458;
            5'd20: r = 32'sd229;
            5'd21: r = 32'sd115;
            5'd22: r = 32'sd57;
            5'd23: r = 32'sd29;
            5'd24: r = 32'sd14;
            5'd25: r = 32'sd7;
            5'd26: r = 32'sd4;
            5'd27: r = 32'sd2;
            5'd28: r = 32'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // wrap a sum of two wrapped angles back to [-180, 180)
    function automatic logic signed [ANG_W-1:0] wrap_sum(input logic signed [ANG_W:0] s);
        logic signed [ANG_W:0] hi;
        logic signed [ANG_W:0] full;
        logic signed [ANG_W:0] r;
        hi   = DEG_180;
        full = DEG_360;
        if (s >= hi) begin
            r = s - full;
        end else if (s < -hi) begin
            r = s + full;
        end else begin
            r = s;
        end
        return r[ANG_W-1:0];
    endfunction

    function automatic logic signed [63:0] round_q30(input logic signed [63:0] p);
        return (p + HALF_Q30) >>> 30;
    endfunction

    function automatic logic signed [F_W-1:0] field_s(input logic [CFG_W-1:0] r,
                                                      input int k);
        return $signed(r[F_W*k +: F_W]);
    endfunction

    function automatic logic [F_W-1:0] field_u(input logic [CFG_W-1:0] r, input int k);
        return r[F_W*k +: F_W];
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX;
        end else if (v < OUT_MIN) begin
            r = OUT_MIN;
        end else begin
            r = v;
        end
        return r[POS_W-1:0];
    endfunction

endpackage

[rtl/core/rafk_joint_angle.sv]
// ----------------------------------------------------------------------------
// rafk_joint_angle
// Two-stage step count to joint angle: product, then wrap to [-180, 180).
// ----------------------------------------------------------------------------
module rafk_joint_angle (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [rafk_pkg::STEP_W-1:0]   steps,
    input  logic        [rafk_pkg::F_W-1:0]      dps,
    output logic signed [rafk_pkg::ANG_W-1:0]    angle_reg
);
    import rafk_pkg::*;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-QUO_LSB-1:0] quo_u;
    logic [24:0]  low;
    logic [13:0]  sum1;
    logic [12:0]  fold;
    logic [27:0]  recip_prod;
    logic [7:0]   quo45;
    logic [12:0]  rem;
    logic [30:0]  ang_u;
    logic signed [ANG_W-1:0] angle_next;

    assign prod_next = steps * $signed({1'b0, dps});

    // 2^12 = 1 mod 45: fold 12-bit chunks, then one reciprocal divide
    always_comb begin
        quo_u      = prod_reg[PROD_W-1:QUO_LSB];
        low        = {prod_reg[QUO_LSB-1:0], 2'b00};
        sum1       = 14'(quo_u[11:0]) + 14'(quo_u[23:12]) + 14'(quo_u[30:24])
                   + (prod_reg[PROD_W-1] ? 14'(MOD45_SIGN_ADJ) : 14'd0);
        fold       = 13'(sum1[11:0]) + 13'(sum1[13:12]);
        recip_prod = 28'(fold) * 28'(RECIP_45);
        quo45      = recip_prod[RECIP_SHIFT +: 8];
        rem        = fold - 13'(quo45) * 13'd45;
        ang_u      = {rem[5:0], low};
        if (ang_u >= 31'(DEG_180)) begin
            angle_next = $signed(32'(ang_u)) - DEG_360;
        end else begin
            angle_next = $signed(32'(ang_u));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            angle_reg <= angle_next;
        end
    end

endmodule

[rtl/core/rafk_cordic_cell.sv]
// ----------------------------------------------------------------------------
// rafk_cordic_cell
// One CORDIC rotation on all lanes, registered toward the next cell.
// ----------------------------------------------------------------------------
module rafk_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               en,
    input  rafk_pkg::cordic_ctl_t                              ctl_in,
    input  logic [rafk_pkg::LANES-1:0][rafk_pkg::CS_W-1:0]     x_in,
    input  logic [rafk_pkg::LANES-1:0][rafk_pkg::CS_W-1:0]     y_in,
    input  logic [rafk_pkg::LANES-1:0][rafk_pkg::ANG_W-1:0]    z_in,
    output rafk_pkg::cordic_ctl_t                              ctl_reg,
    output logic [rafk_pkg::LANES-1:0][rafk_pkg::CS_W-1:0]     x_reg,
    output logic [rafk_pkg::LANES-1:0][rafk_pkg::CS_W-1:0]     y_reg,
    output logic [rafk_pkg::LANES-1:0][rafk_pkg::ANG_W-1:0]    z_reg
);
    import rafk_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = atan_deg(5'(SHIFT));

    logic [LANES-1:0][CS_W-1:0]  x_next, y_next;
    logic [LANES-1:0][ANG_W-1:0] z_next;

    always_comb begin
        logic signed [CS_W-1:0]  xv, yv, dx, dy;
        logic signed [ANG_W-1:0] zv;
        for (int l = 0; l < LANES; l++) begin
            xv = $signed(x_in[l]);
            yv = $signed(y_in[l]);
            zv = $signed(z_in[l]);
            dx = yv >>> SHIFT;
            dy = xv >>> SHIFT;
            if (zv >= 0) begin
                x_next[l] = xv - dx;
                y_next[l] = yv + dy;
                z_next[l] = zv - ATAN;
            end else begin
                x_next[l] = xv + dx;
                y_next[l] = yv - dy;
                z_next[l] = zv + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg.neg <= ctl_in.neg;
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
        end
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_in.valid;
        end
    end

endmodule

[rtl/core/rafk_position.sv]
// ----------------------------------------------------------------------------
// rafk_position
// Segment chaining, base rotation about the pivot and output saturation.
// ----------------------------------------------------------------------------
module rafk_position (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               en,
    input  rafk_pkg::cordic_ctl_t                              ctl_in,
    input  logic [rafk_pkg::LANES-1:0][rafk_pkg::CS_W-1:0]     x_in,
    input  logic [rafk_pkg::LANES-1:0][rafk_pkg::CS_W-1:0]     y_in,
    input  logic [rafk_pkg::CFG_W-1:0]                         pivot,
    input  logic [rafk_pkg::CFG_W-1:0]                         shoulder,
    input  logic [rafk_pkg::CFG_W-1:0]                         wrist,
    input  logic [rafk_pkg::CFG_W-1:0]                         upper,
    input  logic [rafk_pkg::CFG_W-1:0]                         lower,
    output logic                                               out_valid_reg,
    output logic [rafk_pkg::POS_W-1:0]                         pos_x_reg,
    output logic [rafk_pkg::POS_W-1:0]                         pos_y_reg,
    output logic [rafk_pkg::POS_W-1:0]                         pos_z_reg
);
    import rafk_pkg::*;

    localparam int P_W   = CS_W + F_W + 1;
    localparam int SUM_W = 28;
    localparam int M_W   = SUM_W + CS_W;

    logic signed [CS_W-1:0] cv [LANES];
    logic signed [CS_W-1:0] sv [LANES];

    // stage 1: segment products
    logic                   v1_reg, v2_reg, v3_reg;
    logic signed [P_W-1:0]  p2c_reg, p2s_reg, p3c_reg, p3s_reg;
    logic signed [P_W-1:0]  p4c_reg, p4s_reg, p5c_reg, p5s_reg;
    logic signed [CS_W-1:0] c1_reg, s1_reg, c1b_reg, s1b_reg;

    // stage 2: sums
    logic signed [SUM_W-1:0] ox_next, oy_next, z_next;
    logic signed [SUM_W-1:0] ox_reg, oy_reg, z2_reg, z3_reg;

    // stage 3: rotation products
    logic signed [M_W-1:0] mxc_reg, mys_reg, mxs_reg, myc_reg;

    logic signed [31:0] nx, ny;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            cv[l] = ctl_in.neg[l] ? -$signed(x_in[l]) : $signed(x_in[l]);
            sv[l] = ctl_in.neg[l] ? -$signed(y_in[l]) : $signed(y_in[l]);
        end
    end

    always_comb begin
        ox_next = SUM_W'(field_s(shoulder, 0))
                + SUM_W'(round_q30(64'(p2c_reg)))
                + SUM_W'(round_q30(64'(p3c_reg)))
                + SUM_W'(round_q30(64'(p4c_reg)))
                + SUM_W'(field_s(wrist, 0))
                + SUM_W'(round_q30(64'(p5c_reg)))
                - SUM_W'(field_s(pivot, 0));
        oy_next = SUM_W'(field_s(shoulder, 1))
                + SUM_W'(field_s(wrist, 1))
                + SUM_W'(round_q30(64'(p5s_reg)))
                - SUM_W'(field_s(pivot, 1));
        z_next  = SUM_W'(field_s(shoulder, 2))
                + SUM_W'(round_q30(64'(p2s_reg)))
                + SUM_W'(round_q30(64'(p3s_reg)))
                + SUM_W'(round_q30(64'(p4s_reg)));
        nx = 32'(round_q30(64'(mxc_reg) - 64'(mys_reg))) + 32'(field_s(pivot, 0));
        ny = 32'(round_q30(64'(mxs_reg) + 64'(myc_reg))) + 32'(field_s(pivot, 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= ctl_in.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2c_reg <= $signed({1'b0, field_u(upper, 0)}) * cv[LANE_SHLD];
            p2s_reg <= $signed({1'b0, field_u(upper, 0)}) * sv[LANE_SHLD];
            p3c_reg <= $signed({1'b0, field_u(upper, 1)}) * cv[LANE_ELBOW];
            p3s_reg <= $signed({1'b0, field_u(upper, 1)}) * sv[LANE_ELBOW];
            p4c_reg <= $signed({1'b0, field_u(lower, 0)}) * cv[LANE_PITCH];
            p4s_reg <= $signed({1'b0, field_u(lower, 0)}) * sv[LANE_PITCH];
            p5c_reg <= $signed({1'b0, field_u(lower, 1)}) * cv[LANE_WRIST];
            p5s_reg <= $signed({1'b0, field_u(lower, 1)}) * sv[LANE_WRIST];
            c1_reg  <= cv[LANE_BASE];
            s1_reg  <= sv[LANE_BASE];

            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            z2_reg  <= z_next;
            c1b_reg <= c1_reg;
            s1b_reg <= s1_reg;

            mxc_reg <= ox_reg * c1b_reg;
            mys_reg <= oy_reg * s1b_reg;
            mxs_reg <= ox_reg * s1b_reg;
            myc_reg <= oy_reg * c1b_reg;
            z3_reg  <= z2_reg;

            pos_x_reg <= sat_pos(nx);
            pos_y_reg <= sat_pos(ny);
            pos_z_reg <= sat_pos(32'(z3_reg));
        end
    end

endmodule

[rtl/core/robot_arm_forward_kinematics_unit.sv]
// ----------------------------------------------------------------------------
// robot_arm_forward_kinematics_unit
// Five motor step counts in, nozzle X/Y/Z of a five-joint arm out.
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction carries five signed 32-bit step counts.
// Output stream m_*: one transaction per input, X/Y/Z in 1/128 mm, saturated
// to 24 bits. Configuration goes in through cfg_we/cfg_index/cfg_data while
// no pose is in flight; register i of the register list has index i.
//
// The pose runs down a fixed pipeline: two stages turn steps into wrapped
// joint angles, two more form the summed angles and fold them into the
// CORDIC range, then a row of CORDIC_ITERATIONS rotation cells evaluates all
// five sines and cosines side by side, and four stages chain the segments,
// rotate about the base pivot and saturate. One pose is accepted every cycle
// unless the output stalls.
//
// aresetn (synchronous, active low) empties the pipeline and clears every
// configuration register. When m_tready is low with a result waiting, the
// whole pipeline holds and s_tready drops in the same cycle.
// ----------------------------------------------------------------------------
module robot_arm_forward_kinematics_unit #(
    parameter int CORDIC_ITERATIONS = rafk_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // motor1_steps, motor2_steps, motor3_steps, motor4_steps, motor5_steps
    input  logic [5*rafk_pkg::STEP_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pos_x, pos_y, pos_z
    output logic [3*rafk_pkg::POS_W-1:0]  m_tdata,
    input  logic                          cfg_we,
    input  rafk_pkg::cfg_index_t          cfg_index,
    input  logic [rafk_pkg::CFG_W-1:0]    cfg_data
);
    import rafk_pkg::*;

    logic en;

    logic [1:0]           mode_reg;
    logic [CFG_W-1:0]     pivot_reg, shoulder_reg, wrist_reg;
    logic [CFG_W-1:0]     upper_reg, lower_reg, dps123_reg;
    logic [2*F_W-1:0]     dps45_reg;

    logic va_reg, vb_reg, vc_reg;
    logic signed [ANG_W-1:0] j_ang [LANES];
    logic signed [ANG_W-1:0] a23_next, a4_next, a5_next;
    logic signed [ANG_W-1:0] a1c_reg, a2c_reg, a23c_reg, a4c_reg, a5c_reg;
    logic signed [ANG_W-1:0] lane_ang [LANES];

    cordic_ctl_t                  ctl_chain [CORDIC_ITERATIONS+1];
    logic [LANES-1:0][CS_W-1:0]   x_chain   [CORDIC_ITERATIONS+1];
    logic [LANES-1:0][CS_W-1:0]   y_chain   [CORDIC_ITERATIONS+1];
    logic [LANES-1:0][ANG_W-1:0]  z_chain   [CORDIC_ITERATIONS+1];

    cordic_ctl_t                  ctl0_next;
    logic [LANES-1:0][ANG_W-1:0]  z0_next;

    logic [POS_W-1:0] pos_x, pos_y, pos_z;

    // advance everything unless a finished result is stuck at the output
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_FIVE;
            pivot_reg    <= '0;
            shoulder_reg <= '0;
            wrist_reg    <= '0;
            upper_reg    <= '0;
            lower_reg    <= '0;
            dps123_reg   <= '0;
            dps45_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[1:0];
                REG_PIVOT:    pivot_reg    <= cfg_data;
                REG_SHOULDER: shoulder_reg <= cfg_data;
                REG_WRIST:    wrist_reg    <= cfg_data;
                REG_UPPER:    upper_reg    <= cfg_data;
                REG_LOWER:    lower_reg    <= cfg_data;
                REG_DPS123:   dps123_reg   <= cfg_data;
                REG_DPS45:    dps45_reg    <= cfg_data[2*F_W-1:0];
                default: begin
                end
            endcase
        end
    end

    generate
        for (genvar m = 0; m < LANES; m++) begin : g_joint
            logic [F_W-1:0] dps;
            if (m < 3) begin : g_first
                assign dps = dps123_reg[F_W*m +: F_W];
            end else begin : g_last
                assign dps = dps45_reg[F_W*(m-3) +: F_W];
            end
            rafk_joint_angle u_joint (
                .aclk      (aclk),
                .en        (en),
                .steps     ($signed(s_tdata[STEP_W*m +: STEP_W])),
                .dps       (dps),
                .angle_reg (j_ang[m])
            );
        end
    endgenerate

    // summed angles; modes other than five-motor derive joint 4
    always_comb begin
        a23_next = wrap_sum(33'(j_ang[1]) + 33'(j_ang[2]));
        if (mode_reg == MODE_FIVE) begin
            a4_next = j_ang[3];
            a5_next = j_ang[4];
        end else begin
            a4_next = wrap_sum(-33'(DEG_90) - 33'(a23_next));
            a5_next = (mode_reg == MODE_DERIVED) ? j_ang[3] : '0;
        end
    end

    // fold into [-90, 90] and remember which results to negate
    always_comb begin
        lane_ang[LANE_BASE]  = a1c_reg;
        lane_ang[LANE_SHLD]  = a2c_reg;
        lane_ang[LANE_ELBOW] = a23c_reg;
        lane_ang[LANE_PITCH] = wrap_sum(33'(a23c_reg) + 33'(a4c_reg));
        lane_ang[LANE_WRIST] = a5c_reg;
        ctl0_next.valid = vc_reg;
        for (int l = 0; l < LANES; l++) begin
            if (lane_ang[l] > DEG_90) begin
                z0_next[l]       = lane_ang[l] - DEG_180;
                ctl0_next.neg[l] = 1'b1;
            end else if (lane_ang[l] < -DEG_90) begin
                z0_next[l]       = lane_ang[l] + DEG_180;
                ctl0_next.neg[l] = 1'b1;
            end else begin
                z0_next[l]       = lane_ang[l];
                ctl0_next.neg[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg             <= 1'b0;
            vb_reg             <= 1'b0;
            vc_reg             <= 1'b0;
        end else if (en) begin
            va_reg             <= s_tvalid;
            vb_reg             <= va_reg;
            vc_reg             <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1c_reg          <= j_ang[0];
            a2c_reg          <= j_ang[1];
            a23c_reg         <= a23_next;
            a4c_reg          <= a4_next;
            a5c_reg          <= a5_next;
            ctl_chain[0].neg <= ctl0_next.neg;
            z_chain[0]       <= z0_next;
        end
        if (!aresetn) begin
            ctl_chain[0].valid <= 1'b0;
        end else if (en) begin
            ctl_chain[0].valid <= ctl0_next.valid;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            x_chain[0][l] = CORDIC_X0;
            y_chain[0][l] = '0;
        end
    end

    generate
        for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
            rafk_cordic_cell #(
                .SHIFT (i)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .ctl_in  (ctl_chain[i]),
                .x_in    (x_chain[i]),
                .y_in    (y_chain[i]),
                .z_in    (z_chain[i]),
                .ctl_reg (ctl_chain[i+1]),
                .x_reg   (x_chain[i+1]),
                .y_reg   (y_chain[i+1]),
                .z_reg   (z_chain[i+1])
            );
        end
    endgenerate

    rafk_position u_position (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .ctl_in        (ctl_chain[CORDIC_ITERATIONS]),
        .x_in          (x_chain[CORDIC_ITERATIONS]),
        .y_in          (y_chain[CORDIC_ITERATIONS]),
        .pivot         (pivot_reg),
        .shoulder      (shoulder_reg),
        .wrist         (wrist_reg),
        .upper         (upper_reg),
        .lower         (lower_reg),
        .out_valid_reg (m_tvalid),
        .pos_x_reg     (pos_x),
        .pos_y_reg     (pos_y),
        .pos_z_reg     (pos_z)
    );

    assign m_tdata = {pos_z, pos_y, pos_x};

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !va_reg && !ctl_chain[0].valid)
        else $error("pipeline not empty after reset");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> va_reg)
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds_a: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> va_reg == $past(va_reg) && vc_reg == $past(vc_reg))
        else $error("pipeline moved during output stall");

    a_mode_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && cfg_index == REG_MODE |=> mode_reg == $past(cfg_data[1:0]))
        else $error("mode register write lost");

    generate
        for (genvar l = 0; l < LANES; l++) begin : g_fold_chk
            a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
                ctl_chain[0].valid |->
                    $signed(z_chain[0][l]) <= DEG_90 && $signed(z_chain[0][l]) >= -DEG_90)
                else $error("CORDIC input angle out of range");
        end
    endgenerate

endmodule
